// ===== design/rpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the reprojection error inlier check.
// Used by rpe_mul and reprojection_error_inlier_check_top; depends on nothing.
package rpe_pkg;

    localparam int MAX_VIEWS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [31:0] ALLOWED_ERROR_RST  = 32'd131072;
    localparam logic [4:0]  MIN_GOOD_VIEWS_RST = 5'd2;
    localparam logic [4:0]  ACTIVE_VIEWS_RST   = 5'd0;

    // Operand and product widths of the shared multiplier.
    localparam int OPW   = 128;
    localparam int PRODW = 256;

    typedef enum logic [1:0] {
        REG_ALLOWED_ERROR  = 2'd0,
        REG_MIN_GOOD_VIEWS = 2'd1,
        REG_ACTIVE_VIEWS   = 2'd2
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VIEW,
        ST_HRD,
        ST_HMUL,
        ST_HWAIT,
        ST_CHK,
        ST_XRD,
        ST_XMUL,
        ST_XWAIT,
        ST_YRD,
        ST_YMUL,
        ST_YWAIT,
        ST_SQX,
        ST_SQXW,
        ST_SQY,
        ST_SQYW,
        ST_AE,
        ST_AEW,
        ST_RSQ,
        ST_RSQW,
        ST_CMP,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              kind;
        logic [3:0]        view_index;
        logic [3:0]        word_index;
        logic signed [31:0] word_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic       is_bad;
        logic [4:0] good_count;
    } out_t;

endpackage
`default_nettype wire

// ===== design/rpe_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multi-cycle signed multiplier built on one 32x32 unsigned partial product per cycle.
// Depends on rpe_pkg for operand and product widths.
module rpe_mul (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic signed [rpe_pkg::OPW-1:0] a,
    input  wire logic signed [rpe_pkg::OPW-1:0] b,
    input  wire logic [1:0]                    a_last,
    input  wire logic [1:0]                    b_last,
    output logic                               done,
    output logic [rpe_pkg::PRODW-1:0]          prod
);

    logic [rpe_pkg::OPW-1:0]   mag_a_reg;
    logic [rpe_pkg::OPW-1:0]   mag_b_reg;
    logic                      neg_reg;
    logic [1:0]                ia_reg;
    logic [1:0]                ib_reg;
    logic [1:0]                al_reg;
    logic [1:0]                bl_reg;
    logic                      run_reg;
    logic                      fin_reg;
    logic                      done_reg;
    logic [rpe_pkg::PRODW-1:0] acc_reg;

    logic [63:0]               part;
    logic [2:0]                limb_sum;
    logic [rpe_pkg::PRODW-1:0] part_shifted;

    always_comb begin
        part         = 64'(mag_a_reg[{ia_reg, 5'b0} +: 32]) * 64'(mag_b_reg[{ib_reg, 5'b0} +: 32]);
        limb_sum     = 3'(ia_reg) + 3'(ib_reg);
        part_shifted = {{(rpe_pkg::PRODW-64){1'b0}}, part} << {limb_sum, 5'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                fin_reg <= 1'b0;
            end else if (run_reg) begin
                if (ib_reg == bl_reg && ia_reg == al_reg) begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= a[rpe_pkg::OPW-1] ? -a : a;
            mag_b_reg <= b[rpe_pkg::OPW-1] ? -b : b;
            neg_reg   <= a[rpe_pkg::OPW-1] ^ b[rpe_pkg::OPW-1];
            al_reg    <= a_last;
            bl_reg    <= b_last;
            ia_reg    <= 2'd0;
            ib_reg    <= 2'd0;
            acc_reg   <= '0;
        end else if (run_reg) begin
            acc_reg <= acc_reg + part_shifted;
            if (ib_reg == bl_reg) begin
                ib_reg <= 2'd0;
                ia_reg <= ia_reg + 2'd1;
            end else begin
                ib_reg <= ib_reg + 2'd1;
            end
        end else if (fin_reg) begin
            // Sign is applied once to the accumulated magnitude.
            acc_reg <= neg_reg ? -acc_reg : acc_reg;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ===== design/reprojection_error_inlier_check_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reprojection error inlier check. Write items are taken one per cycle while the block is idle.
// A test item is worked view by view after its transfer and fills the result register; a view
// whose depth is zero or negative skips the error check. The work runs on the shared
// 32x32 multiplier that walks every product limb by limb; the next item can enter once the result is registered.
// The result sits in an output register, so the next item can enter while it waits.
// Synchronous active-low reset clears control and configuration; the table memories
// are not cleared and hold garbage until written.
module reprojection_error_inlier_check_top #(
    parameter int MAX_VIEWS = rpe_pkg::MAX_VIEWS_DEF,
    parameter int FRAC_BITS = rpe_pkg::FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rpe_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rpe_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int PDEPTH = MAX_VIEWS * 12;
    localparam int ODEPTH = MAX_VIEWS * 2;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int OAW    = (ODEPTH > 1) ? $clog2(ODEPTH) : 1;
    localparam int CW     = $clog2(MAX_VIEWS + 1);
    localparam int HW     = 68;
    localparam int OPW    = rpe_pkg::OPW;
    localparam int PRODW  = rpe_pkg::PRODW;
    localparam logic signed [OPW-1:0] ONE = OPW'(1) << FRAC_BITS;

    // Configuration registers.
    logic [31:0] allowed_error_reg;
    logic [4:0]  min_good_reg;
    logic [4:0]  active_reg;

    // Table memories.
    logic [31:0] proj_mem [PDEPTH];
    logic [31:0] obs_mem  [ODEPTH];
    logic [31:0] proj_rdata_reg;
    logic [31:0] obs_rdata_reg;
    logic [PAW-1:0] proj_raddr;
    logic [OAW-1:0] obs_raddr;
    logic [PAW-1:0] proj_waddr;
    logic [OAW-1:0] obs_waddr;

    rpe_pkg::state_t state_reg, state_next;

    logic signed [31:0] ptx_reg, pty_reg, ptz_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      view_reg;
    logic [CW-1:0]      good_reg;
    logic [3:0]         k_reg;
    logic signed [HW-1:0] hx_reg, hy_reg, hw_reg;
    logic signed [OPW-1:0] ex_reg, ey_reg, aehw_reg;
    logic [PRODW-1:0]   lhs_reg, rhs_reg;

    logic               m_valid_reg;
    rpe_pkg::out_t      m_data_reg;

    logic               in_xfer;
    logic               out_free;
    logic               mul_start;
    logic signed [OPW-1:0] mul_a, mul_b;
    logic [1:0]         mul_al, mul_bl;
    logic               obs_sel;
    logic               mul_done;
    logic [PRODW-1:0]   mul_prod;
    logic signed [31:0] pt_sel;
    logic [31:0]        act32;

    rpe_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .a_last  (mul_al),
        .b_last  (mul_bl),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign act32     = 32'(active_reg);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_error_reg <= rpe_pkg::ALLOWED_ERROR_RST;
            min_good_reg      <= rpe_pkg::MIN_GOOD_VIEWS_RST;
            active_reg        <= rpe_pkg::ACTIVE_VIEWS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                rpe_pkg::REG_ALLOWED_ERROR:  allowed_error_reg <= cfg_data;
                rpe_pkg::REG_MIN_GOOD_VIEWS: min_good_reg      <= cfg_data[4:0];
                rpe_pkg::REG_ACTIVE_VIEWS:   active_reg        <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Table writes land directly from the input transfer.
    assign proj_waddr = PAW'(32'(s_data.view_index) * 12 + 32'(s_data.word_index));
    assign obs_waddr  = OAW'(32'(s_data.view_index) * 2 + 32'(s_data.word_index) - 12);
    assign proj_raddr = PAW'(32'(view_reg) * 12 + 32'(k_reg));
    assign obs_raddr  = OAW'(32'(view_reg) * 2 + 32'(obs_sel));

    always_ff @(posedge aclk) begin
        if (in_xfer && !s_data.kind && 32'(s_data.view_index) < MAX_VIEWS) begin
            if (s_data.word_index < 4'd12) begin
                proj_mem[proj_waddr] <= s_data.word_value;
            end else if (s_data.word_index < 4'd14) begin
                obs_mem[obs_waddr] <= s_data.word_value;
            end
        end
        proj_rdata_reg <= proj_mem[proj_raddr];
        obs_rdata_reg  <= obs_mem[obs_raddr];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpe_pkg::ST_IDLE:  if (in_xfer && s_data.kind) state_next = rpe_pkg::ST_VIEW;
            rpe_pkg::ST_VIEW:  state_next = (view_reg < n_reg) ? rpe_pkg::ST_HRD : rpe_pkg::ST_DONE;
            rpe_pkg::ST_HRD:   state_next = rpe_pkg::ST_HMUL;
            rpe_pkg::ST_HMUL:  state_next = rpe_pkg::ST_HWAIT;
            rpe_pkg::ST_HWAIT: begin
                if (mul_done) begin
                    state_next = (k_reg == 4'd11) ? rpe_pkg::ST_CHK : rpe_pkg::ST_HRD;
                end
            end
            rpe_pkg::ST_CHK: begin
                state_next = (hw_reg > 0) ? rpe_pkg::ST_XRD : rpe_pkg::ST_NEXT;
            end
            rpe_pkg::ST_XRD:   state_next = rpe_pkg::ST_XMUL;
            rpe_pkg::ST_XMUL:  state_next = rpe_pkg::ST_XWAIT;
            rpe_pkg::ST_XWAIT: if (mul_done) state_next = rpe_pkg::ST_YRD;
            rpe_pkg::ST_YRD:   state_next = rpe_pkg::ST_YMUL;
            rpe_pkg::ST_YMUL:  state_next = rpe_pkg::ST_YWAIT;
            rpe_pkg::ST_YWAIT: if (mul_done) state_next = rpe_pkg::ST_SQX;
            rpe_pkg::ST_SQX:   state_next = rpe_pkg::ST_SQXW;
            rpe_pkg::ST_SQXW:  if (mul_done) state_next = rpe_pkg::ST_SQY;
            rpe_pkg::ST_SQY:   state_next = rpe_pkg::ST_SQYW;
            rpe_pkg::ST_SQYW:  if (mul_done) state_next = rpe_pkg::ST_AE;
            rpe_pkg::ST_AE:    state_next = rpe_pkg::ST_AEW;
            rpe_pkg::ST_AEW:   if (mul_done) state_next = rpe_pkg::ST_RSQ;
            rpe_pkg::ST_RSQ:   state_next = rpe_pkg::ST_RSQW;
            rpe_pkg::ST_RSQW:  if (mul_done) state_next = rpe_pkg::ST_CMP;
            rpe_pkg::ST_CMP:   state_next = rpe_pkg::ST_NEXT;
            rpe_pkg::ST_NEXT:  state_next = rpe_pkg::ST_VIEW;
            rpe_pkg::ST_DONE:  if (out_free) state_next = rpe_pkg::ST_IDLE;
            default:           state_next = rpe_pkg::ST_IDLE;
        endcase
    end

    // Control outputs and multiplier operand selection.
    always_comb begin
        case (k_reg[1:0])
            2'd0:    pt_sel = ptx_reg;
            2'd1:    pt_sel = pty_reg;
            default: pt_sel = ptz_reg;
        endcase
        s_ready   = (state_reg == rpe_pkg::ST_IDLE);
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_al    = 2'd0;
        mul_bl    = 2'd0;
        obs_sel   = (state_reg == rpe_pkg::ST_YRD);
        case (state_reg)
            rpe_pkg::ST_HMUL: begin
                mul_start = 1'b1;
                mul_a     = OPW'(signed'(proj_rdata_reg));
                mul_b     = (k_reg[1:0] == 2'd3) ? ONE : OPW'(pt_sel);
            end
            rpe_pkg::ST_XMUL, rpe_pkg::ST_YMUL: begin
                mul_start = 1'b1;
                mul_a     = OPW'(signed'(obs_rdata_reg));
                mul_b     = OPW'(hw_reg);
                mul_bl    = 2'd2;
            end
            rpe_pkg::ST_SQX: begin
                mul_start = 1'b1;
                mul_a     = ex_reg;
                mul_b     = ex_reg;
                mul_al    = 2'd3;
                mul_bl    = 2'd3;
            end
            rpe_pkg::ST_SQY: begin
                mul_start = 1'b1;
                mul_a     = ey_reg;
                mul_b     = ey_reg;
                mul_al    = 2'd3;
                mul_bl    = 2'd3;
            end
            rpe_pkg::ST_AE: begin
                mul_start = 1'b1;
                mul_a     = OPW'(allowed_error_reg);
                mul_b     = OPW'(hw_reg);
                mul_bl    = 2'd2;
            end
            rpe_pkg::ST_RSQ: begin
                mul_start = 1'b1;
                mul_a     = aehw_reg;
                mul_b     = aehw_reg;
                mul_al    = 2'd3;
                mul_bl    = 2'd3;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Per-test datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            rpe_pkg::ST_IDLE: begin
                ptx_reg  <= s_data.point_x;
                pty_reg  <= s_data.point_y;
                ptz_reg  <= s_data.point_z;
                n_reg    <= CW'((act32 > 32'(MAX_VIEWS)) ? 32'(MAX_VIEWS) : act32);
                view_reg <= '0;
                good_reg <= '0;
            end
            rpe_pkg::ST_VIEW: begin
                k_reg  <= 4'd0;
                hx_reg <= '0;
                hy_reg <= '0;
                hw_reg <= '0;
            end
            rpe_pkg::ST_HWAIT: begin
                if (mul_done) begin
                    case (k_reg[3:2])
                        2'd0:    hx_reg <= hx_reg + signed'(HW'(mul_prod));
                        2'd1:    hy_reg <= hy_reg + signed'(HW'(mul_prod));
                        default: hw_reg <= hw_reg + signed'(HW'(mul_prod));
                    endcase
                    k_reg <= k_reg + 4'd1;
                end
            end
            rpe_pkg::ST_XWAIT: begin
                if (mul_done) begin
                    ex_reg <= signed'(OPW'(mul_prod)) - (OPW'(hx_reg) <<< FRAC_BITS);
                end
            end
            rpe_pkg::ST_YWAIT: begin
                if (mul_done) begin
                    ey_reg <= signed'(OPW'(mul_prod)) - (OPW'(hy_reg) <<< FRAC_BITS);
                end
            end
            rpe_pkg::ST_SQXW: if (mul_done) lhs_reg <= mul_prod;
            rpe_pkg::ST_SQYW: if (mul_done) lhs_reg <= lhs_reg + mul_prod;
            rpe_pkg::ST_AEW:  if (mul_done) aehw_reg <= signed'(OPW'(mul_prod));
            rpe_pkg::ST_RSQW: if (mul_done) rhs_reg <= mul_prod;
            rpe_pkg::ST_CMP: begin
                // Both sides are non-negative here, so an unsigned compare is exact.
                if (lhs_reg <= rhs_reg) good_reg <= good_reg + CW'(1);
            end
            rpe_pkg::ST_NEXT: view_reg <= view_reg + CW'(1);
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == rpe_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == rpe_pkg::ST_DONE && out_free) begin
            m_data_reg.is_bad     <= (32'(good_reg) < 32'(min_good_reg));
            m_data_reg.good_count <= 5'(good_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
